// File: hdl/mpf_pkg.sv
`timescale 1ns / 1ps
// shared types and codes for the multilevel priority fifo
// no dependencies

package mpf_pkg;

  typedef enum logic [1:0] {
    ACT_ADD    = 2'd0,
    ACT_REMOVE = 2'd1,
    ACT_QUERY  = 2'd2
  } action_e;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_EXEC = 4'b0010,
    S_READ = 4'b0100,
    S_RESP = 4'b1000
  } state_e;

  typedef struct packed {
    logic [1:0]  action;
    logic [2:0]  priority_req;
    logic [15:0] task_tag;
  } item_t;

  typedef struct packed {
    logic        done_res;
    logic        overflow;
    logic        found;
    logic [15:0] front_tag;
    logic [2:0]  front_level;
    logic [7:0]  total_count;
    logic [4:0]  level_count;
  } result_t;

  typedef struct packed {
    logic        exec;
    logic [1:0]  action;
    logic [2:0]  level;
    logic [15:0] tag;
  } cell_ctrl_t;

  typedef struct packed {
    logic        busy;
    logic        matched;
    logic        full;
    logic [15:0] front_tag;
    logic [2:0]  front_level;
    logic [4:0]  level_count;
  } chain_t;

endpackage

// File: hdl/mpf_if.sv
`timescale 1ns / 1ps
// valid/ready channel interfaces for input items and results
// depends on mpf_pkg

interface mpf_in_if import mpf_pkg::*; ();
  logic  valid;
  logic  ready;
  item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface mpf_out_if import mpf_pkg::*; ();
  logic    valid;
  logic    ready;
  result_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// File: hdl/mpf_cell.sv
`timescale 1ns / 1ps
// one priority level: its tag fifo, pointers and fill, plus its link in the chain
// depends on mpf_pkg

module mpf_cell import mpf_pkg::*; #(
  parameter int ID          = 0,
  parameter int LEVEL_DEPTH = 16,
  parameter int TAG_BITS    = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cell_ctrl_t ctrl_i,
  input  chain_t     chain_i,
  output chain_t     chain_o
);

  localparam int PTR_W  = $clog2(LEVEL_DEPTH);
  localparam int FILL_W = $clog2(LEVEL_DEPTH + 1);
  localparam bit Addressable = (ID < 8);
  localparam logic [2:0] LvlCode = 3'(ID);

  logic [PTR_W-1:0]    head_q, head_d, tail_q, tail_d;
  logic [FILL_W-1:0]   fill_q, fill_d;
  logic [TAG_BITS-1:0] mem_q [LEVEL_DEPTH];
  logic [TAG_BITS-1:0] rd_q;

  logic nonempty, first, match, full, do_add, do_rem;

  function automatic logic [PTR_W-1:0] advance(input logic [PTR_W-1:0] ptr);
    return (ptr == PTR_W'(LEVEL_DEPTH - 1)) ? '0 : ptr + PTR_W'(1);
  endfunction

  assign nonempty = (fill_q != '0);
  assign first    = nonempty && !chain_i.busy;
  assign match    = Addressable && (ctrl_i.level == LvlCode);
  assign full     = (fill_q == FILL_W'(LEVEL_DEPTH));
  assign do_add   = ctrl_i.exec && (ctrl_i.action == ACT_ADD) && match && !full;
  assign do_rem   = ctrl_i.exec && (ctrl_i.action == ACT_REMOVE) && first;

  always_comb begin
    head_d = head_q;
    tail_d = tail_q;
    fill_d = fill_q;
    if (do_add) begin
      tail_d = advance(tail_q);
      fill_d = fill_q + FILL_W'(1);
    end
    if (do_rem) begin
      head_d = advance(head_q);
      fill_d = fill_q - FILL_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= '0;
      tail_q <= '0;
      fill_q <= '0;
    end else begin
      head_q <= head_d;
      tail_q <= tail_d;
      fill_q <= fill_d;
    end
  end

  // tag storage, one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (do_add) begin
      mem_q[tail_q] <= TAG_BITS'(ctrl_i.tag);
    end
    rd_q <= mem_q[head_q];
  end

  always_comb begin
    chain_o.busy        = chain_i.busy || nonempty;
    chain_o.matched     = chain_i.matched || match;
    chain_o.full        = chain_i.full || (match && full);
    chain_o.front_tag   = first ? 16'(rd_q) : chain_i.front_tag;
    chain_o.front_level = first ? LvlCode : chain_i.front_level;
    chain_o.level_count = match ? 5'(fill_q) : chain_i.level_count;
  end

endmodule

// File: hdl/multilevel_priority_fifo.sv
`timescale 1ns / 1ps
// top level of the multilevel priority fifo: sequencer, counters and the row of level cells
// depends on mpf_pkg, mpf_if and mpf_cell
//
//   port    dir   handshake      payload
//   in_i    sink  valid/ready    action, priority_req, task_tag
//   out_o   src   valid/ready    done_res, overflow, found, front_tag, front_level,
//                                total_count, level_count
//
// each transaction steps through the sequencer: accept, update the cells, read the head tag
// from the cell memories, then resolve the front through the chain of cells.
// the chain from level 0 upward picks the most urgent non-empty level.
// rst_ni clears pointers, fills and the sequencer; tag storage is not cleared.
// a result waiting in the output register holds the sequencer before it is loaded.

module multilevel_priority_fifo import mpf_pkg::*; #(
  parameter int LEVELS      = 8,
  parameter int LEVEL_DEPTH = 16,
  parameter int TAG_BITS    = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  mpf_in_if.sink    in_i,
  mpf_out_if.source out_o
);

  localparam int TOT_W = $clog2(LEVELS * LEVEL_DEPTH + 1);

  state_e           state_q, state_d;
  item_t            item_q;
  logic             done_q, ovf_q;
  logic [TOT_W-1:0] all_fill_q;
  logic             out_valid_q;
  result_t          out_data_q;
  cell_ctrl_t       ctrl;
  chain_t           link [LEVELS+1];
  logic             accept, add_ok, add_ovf, rem_ok, load_out;

  assign accept = in_i.valid && in_i.ready;
  assign in_i.ready = (state_q == S_IDLE);

  assign ctrl.exec   = (state_q == S_EXEC);
  assign ctrl.action = item_q.action;
  assign ctrl.level  = item_q.priority_req;
  assign ctrl.tag    = item_q.task_tag;

  assign link[0] = '0;

  for (genvar g = 0; g < LEVELS; g++) begin : g_cell
    mpf_cell #(
      .ID          (g),
      .LEVEL_DEPTH (LEVEL_DEPTH),
      .TAG_BITS    (TAG_BITS)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctrl_i  (ctrl),
      .chain_i (link[g]),
      .chain_o (link[g+1])
    );
  end

  assign add_ok  = (item_q.action == ACT_ADD) && link[LEVELS].matched && !link[LEVELS].full;
  assign add_ovf = (item_q.action == ACT_ADD) && link[LEVELS].full;
  assign rem_ok  = (item_q.action == ACT_REMOVE) && link[LEVELS].busy;
  assign load_out = (state_q == S_RESP) && (!out_valid_q || out_o.ready);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: if (accept) state_d = S_EXEC;
      S_EXEC: state_d = S_READ;
      S_READ: state_d = S_RESP;
      S_RESP: if (load_out) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      all_fill_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (ctrl.exec && add_ok) begin
        all_fill_q <= all_fill_q + TOT_W'(1);
      end else if (ctrl.exec && rem_ok) begin
        all_fill_q <= all_fill_q - TOT_W'(1);
      end
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= in_i.payload;
    end
    if (ctrl.exec) begin
      done_q <= add_ok || rem_ok;
      ovf_q  <= add_ovf;
    end
    if (load_out) begin
      out_data_q.done_res    <= done_q;
      out_data_q.overflow    <= ovf_q;
      out_data_q.found       <= link[LEVELS].busy;
      out_data_q.front_tag   <= link[LEVELS].front_tag;
      out_data_q.front_level <= link[LEVELS].front_level;
      out_data_q.total_count <= 8'(all_fill_q);
      out_data_q.level_count <= link[LEVELS].level_count;
    end
  end

  assign out_o.valid   = out_valid_q;
  assign out_o.payload = out_data_q;

  a_accept_starts_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q == S_EXEC))
    else $error("accepted transaction did not start execution");

  a_state_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(state_q))
    else $error("sequencer state lost its one-hot code");

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    all_fill_q <= TOT_W'(LEVELS * LEVEL_DEPTH))
    else $error("total fill exceeds capacity");

  a_done_ovf_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(out_data_q.done_res && out_data_q.overflow))
    else $error("done and overflow raised together");

  a_empty_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_data_q.found) |-> (out_data_q.total_count == 8'd0))
    else $error("nothing found but total count nonzero");

endmodule
